// File: rtl/core/tslru_pkg.sv
package tslru_pkg;

   localparam int SEGMENT_ENTRIES = 256;
   localparam int BLOCK_BITS      = 20;
   localparam int ADDR_BITS       = 20;
   localparam int CFG_DATA_BITS   = 9;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int COUNT_BITS      = 32;
   localparam int IDX_BITS        = $clog2(SEGMENT_ENTRIES);
   localparam int FILL_BITS       = $clog2(SEGMENT_ENTRIES + 1);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_SIZE  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SECOND_SIZE = CSR_INDEX_BITS'(1);

   localparam logic [1:0] FOUND_NONE   = 2'd0;
   localparam logic [1:0] FOUND_FIRST  = 2'd1;
   localparam logic [1:0] FOUND_SECOND = 2'd2;

   typedef enum logic [2:0] {
      MODE_INSERT,
      MODE_SEARCH,
      MODE_PULL,
      MODE_EXIT,
      MODE_DONE
   } wave_mode_type;

   typedef struct packed {
      logic                  active;
      wave_mode_type         mode;
      logic [BLOCK_BITS-1:0] carry;
      logic [1:0]            found;
      logic                  first_inc;
      logic                  second_inc;
      logic                  second_dec;
   } wave_type;

   typedef struct packed {
      logic [FILL_BITS-1:0] fill;
      logic                 full;
   } seg_ctl_type;

   function automatic logic [FILL_BITS-1:0] clamp_size(input logic [CFG_DATA_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      if (w == 32'd0) begin
         w = 32'd1;
      end
      if (w > 32'(SEGMENT_ENTRIES)) begin
         w = 32'(SEGMENT_ENTRIES);
      end
      return w[FILL_BITS-1:0];
   endfunction

   localparam logic [FILL_BITS-1:0] SIZE_RESET = clamp_size(CFG_DATA_BITS'(256));

endpackage

// File: rtl/core/tslru_ifs.sv
interface tslru_req_if import tslru_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ADDR_BITS-1:0] block_address;

   modport source (output valid, output block_address, input ready);
   modport sink   (input valid, input block_address, output ready);
endinterface

interface tslru_rsp_if import tslru_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  was_hit;
   logic [1:0]            found_segment;
   logic                  evicted_valid;
   logic [ADDR_BITS-1:0]  evicted_block;
   logic [COUNT_BITS-1:0] hit_total;
   logic [COUNT_BITS-1:0] miss_total;

   modport source (output valid, output was_hit, output found_segment, output evicted_valid,
                   output evicted_block, output hit_total, output miss_total, input ready);
   modport sink   (input valid, input was_hit, input found_segment, input evicted_valid,
                   input evicted_block, input hit_total, input miss_total, output ready);
endinterface

interface tslru_csr_if import tslru_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CFG_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/two_segment_lru_cache_tracker_top.sv
// A request passes through the entry register, the update wave's 512-cell recency chain (one cell per
// cycle), the pending register and the response register; a new request is accepted only once the
// previous result has moved to the response register, which waits while rsp_ ready is low.
// Reset (synchronous, active high): fills and hit/miss counters cleared, both segment
// sizes set to 256, pipeline emptied; tag cells are not cleared and need no clearing pass.
module two_segment_lru_cache_tracker_top import tslru_pkg::*; (
   input logic         clock,
   input logic         reset,
   tslru_req_if.sink   req_chan,
   tslru_rsp_if.source rsp_chan,
   tslru_csr_if.sink   csr_chan
);

   logic                  req_accept, csr_accept, move;
   logic                  busy_ff, busy_in;
   logic [BLOCK_BITS-1:0] search_ff, search_in;
   wave_type              entry_ff, entry_in;
   wave_type              mid_wave, second_entry, last_wave;
   seg_ctl_type           first_ctl, second_ctl;

   logic [FILL_BITS-1:0]  first_size_ff, first_size_in, second_size_ff, second_size_in;
   logic [FILL_BITS-1:0]  first_fill_ff, first_fill_in, second_fill_ff, second_fill_in;
   logic [FILL_BITS-1:0]  new_size;
   logic [COUNT_BITS-1:0] hit_cnt_ff, hit_cnt_in, miss_cnt_ff, miss_cnt_in;

   logic                  pend_valid_ff, pend_valid_in;
   logic                  pend_hit_ff, pend_hit_in;
   logic [1:0]            pend_found_ff, pend_found_in;
   logic                  pend_ev_ff, pend_ev_in;
   logic [ADDR_BITS-1:0]  pend_block_ff, pend_block_in;
   logic [COUNT_BITS-1:0] pend_hits_ff, pend_hits_in, pend_miss_ff, pend_miss_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff;
   logic [1:0]            rsp_found_ff;
   logic                  rsp_ev_ff;
   logic [ADDR_BITS-1:0]  rsp_block_ff;
   logic [COUNT_BITS-1:0] rsp_hits_ff, rsp_miss_ff;

   assign req_chan.ready = !busy_ff;
   assign csr_chan.ready = 1'b1;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_accept     = csr_chan.valid && csr_chan.ready;
   assign move           = pend_valid_ff && (!rsp_valid_ff || rsp_chan.ready);

   assign first_ctl.fill  = first_fill_ff;
   assign first_ctl.full  = first_fill_ff >= first_size_ff;
   assign second_ctl.fill = second_fill_ff;
   assign second_ctl.full = second_fill_ff >= second_size_ff;

   always_comb begin
      entry_in            = '0;
      entry_in.active     = req_accept;
      entry_in.mode       = MODE_INSERT;
      entry_in.carry      = req_chan.block_address[BLOCK_BITS-1:0];
      search_in           = req_accept ? req_chan.block_address[BLOCK_BITS-1:0] : search_ff;
   end

   // demoted tail of the first segment enters the second as an insert
   always_comb begin
      second_entry = mid_wave;
      if (mid_wave.mode == MODE_EXIT) begin
         second_entry.mode = MODE_INSERT;
      end
   end

   tslru_segment u_first (
      .clock      (clock),
      .reset      (reset),
      .second_seg (1'b0),
      .ctl        (first_ctl),
      .search     (search_ff),
      .wave_entry (entry_ff),
      .wave_exit  (mid_wave)
   );

   tslru_segment u_second (
      .clock      (clock),
      .reset      (reset),
      .second_seg (1'b1),
      .ctl        (second_ctl),
      .search     (search_ff),
      .wave_entry (second_entry),
      .wave_exit  (last_wave)
   );

   always_comb begin
      busy_in        = busy_ff;
      first_size_in  = first_size_ff;
      second_size_in = second_size_ff;
      first_fill_in  = first_fill_ff;
      second_fill_in = second_fill_ff;
      hit_cnt_in     = hit_cnt_ff;
      miss_cnt_in    = miss_cnt_ff;
      new_size       = clamp_size(csr_chan.data);
      pend_valid_in  = pend_valid_ff;
      pend_hit_in    = last_wave.found != FOUND_NONE;
      pend_found_in  = last_wave.found;
      pend_ev_in     = last_wave.mode == MODE_EXIT;
      pend_block_in  = (last_wave.mode == MODE_EXIT) ? ADDR_BITS'(last_wave.carry) : '0;

      if (req_accept) begin
         busy_in = 1'b1;
      end else if (move) begin
         busy_in = 1'b0;
      end

      if (last_wave.active) begin
         pend_valid_in  = 1'b1;
         first_fill_in  = first_fill_ff + FILL_BITS'(last_wave.first_inc);
         second_fill_in = second_fill_ff + FILL_BITS'(last_wave.second_inc)
                          - FILL_BITS'(last_wave.second_dec);
         if (last_wave.found != FOUND_NONE) begin
            hit_cnt_in = hit_cnt_ff + COUNT_BITS'(1);
         end else begin
            miss_cnt_in = miss_cnt_ff + COUNT_BITS'(1);
         end
      end else if (move) begin
         pend_valid_in = 1'b0;
      end

      if (csr_accept) begin
         case (csr_chan.index)
            CSR_FIRST_SIZE: begin
               first_size_in = new_size;
               if (first_fill_ff > new_size) begin
                  first_fill_in = new_size;
               end
            end
            CSR_SECOND_SIZE: begin
               second_size_in = new_size;
               if (second_fill_ff > new_size) begin
                  second_fill_in = new_size;
               end
            end
            default: begin
            end
         endcase
      end

      pend_hits_in = hit_cnt_in;
      pend_miss_in = miss_cnt_in;

      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         entry_ff.active <= 1'b0;
         first_size_ff  <= SIZE_RESET;
         second_size_ff <= SIZE_RESET;
         first_fill_ff  <= '0;
         second_fill_ff <= '0;
         hit_cnt_ff     <= '0;
         miss_cnt_ff    <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         entry_ff       <= entry_in;
         first_size_ff  <= first_size_in;
         second_size_ff <= second_size_in;
         first_fill_ff  <= first_fill_in;
         second_fill_ff <= second_fill_in;
         hit_cnt_ff     <= hit_cnt_in;
         miss_cnt_ff    <= miss_cnt_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      search_ff <= search_in;
      if (last_wave.active) begin
         pend_hit_ff   <= pend_hit_in;
         pend_found_ff <= pend_found_in;
         pend_ev_ff    <= pend_ev_in;
         pend_block_ff <= pend_block_in;
         pend_hits_ff  <= pend_hits_in;
         pend_miss_ff  <= pend_miss_in;
      end
      if (move) begin
         rsp_hit_ff   <= pend_hit_ff;
         rsp_found_ff <= pend_found_ff;
         rsp_ev_ff    <= pend_ev_ff;
         rsp_block_ff <= pend_block_ff;
         rsp_hits_ff  <= pend_hits_ff;
         rsp_miss_ff  <= pend_miss_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.was_hit       = rsp_hit_ff;
   assign rsp_chan.found_segment = rsp_found_ff;
   assign rsp_chan.evicted_valid = rsp_ev_ff;
   assign rsp_chan.evicted_block = rsp_block_ff;
   assign rsp_chan.hit_total     = rsp_hits_ff;
   assign rsp_chan.miss_total    = rsp_miss_ff;

`ifndef SYNTH
   a_first_fill: assert property (@(posedge clock) disable iff (reset)
      first_fill_ff <= first_size_ff) else $error("first segment overfilled");
   a_second_fill: assert property (@(posedge clock) disable iff (reset)
      second_fill_ff <= second_size_ff) else $error("second segment overfilled");
   a_exit_busy: assert property (@(posedge clock) disable iff (reset)
      last_wave.active |-> busy_ff && !pend_valid_ff) else $error("stray wave at chain end");
   a_accept_wave: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> busy_ff && entry_ff.active) else $error("transaction not launched");
   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> busy_ff) else $error("pending result while idle");
`endif

endmodule

// File: rtl/core/tslru_cell.sv
module tslru_cell import tslru_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [IDX_BITS-1:0]   cell_index,
   input  logic                  second_seg,
   input  seg_ctl_type           ctl,
   input  logic [BLOCK_BITS-1:0] search,
   input  logic [BLOCK_BITS-1:0] right_tag,
   input  wave_type              prev_wave,
   output wave_type              next_wave,
   output logic [BLOCK_BITS-1:0] tag_out
);

   logic [BLOCK_BITS-1:0] tag_ff, tag_in;
   wave_type              wave_ff, wave_in;
   logic [FILL_BITS-1:0]  pos;
   logic                  occ, last, at, match;

   assign pos   = FILL_BITS'(cell_index);
   assign occ   = pos < ctl.fill;
   assign last  = occ && ((pos + FILL_BITS'(1)) == ctl.fill);
   assign at    = pos == ctl.fill;
   assign match = tag_ff == search;

   always_comb begin
      tag_in  = tag_ff;
      wave_in = prev_wave;
      if (prev_wave.active) begin
         case (prev_wave.mode)
            MODE_INSERT: begin
               if (occ) begin
                  tag_in = prev_wave.carry;
                  if (match) begin
                     wave_in.mode  = MODE_DONE;
                     wave_in.found = second_seg ? FOUND_SECOND : FOUND_FIRST;
                  end else begin
                     wave_in.carry = tag_ff;
                     if (last && ctl.full) begin
                        wave_in.mode = MODE_EXIT;
                     end
                  end
               end else if (at) begin
                  tag_in = prev_wave.carry;
                  if (second_seg) begin
                     wave_in.mode       = MODE_DONE;
                     wave_in.second_inc = 1'b1;
                  end else begin
                     wave_in.mode      = MODE_SEARCH;
                     wave_in.first_inc = 1'b1;
                  end
               end
            end
            MODE_SEARCH: begin
               if (occ && match) begin
                  tag_in             = right_tag;
                  wave_in.mode       = MODE_PULL;
                  wave_in.found      = FOUND_SECOND;
                  wave_in.second_dec = 1'b1;
               end
            end
            MODE_PULL: begin
               if (occ) begin
                  tag_in = right_tag;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff.active <= 1'b0;
      end else begin
         wave_ff <= wave_in;
      end
   end

   assign next_wave = wave_ff;
   assign tag_out   = tag_ff;

endmodule

// File: rtl/core/tslru_segment.sv
module tslru_segment import tslru_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  second_seg,
   input  seg_ctl_type           ctl,
   input  logic [BLOCK_BITS-1:0] search,
   input  wave_type              wave_entry,
   output wave_type              wave_exit
);

   wave_type              link [SEGMENT_ENTRIES+1];
   logic [BLOCK_BITS-1:0] tags [SEGMENT_ENTRIES];

   assign link[0]   = wave_entry;
   assign wave_exit = link[SEGMENT_ENTRIES];

   for (genvar g = 0; g < SEGMENT_ENTRIES; g++) begin : g_cell
      logic [BLOCK_BITS-1:0] right;
      if (g < SEGMENT_ENTRIES - 1) begin : g_mid
         assign right = tags[g+1];
      end else begin : g_end
         assign right = tags[g];
      end

      tslru_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_BITS'(g)),
         .second_seg (second_seg),
         .ctl        (ctl),
         .search     (search),
         .right_tag  (right),
         .prev_wave  (link[g]),
         .next_wave  (link[g+1]),
         .tag_out    (tags[g])
      );
   end

endmodule
